>>> src/lbs_pkg.sv
// shared constants, codes and record types of the led blink sequencer
`default_nettype none

package lbs_pkg;

	// block size
	localparam int NUM_LEDS      = 8;
	localparam int PATTERN_DEPTH = 16;

	// derived widths
	localparam int LED_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int PAT_AW     = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int LEN_W      = $clog2(PATTERN_DEPTH + 1);
	localparam int PAT_TOTAL  = NUM_LEDS * PATTERN_DEPTH;
	localparam int PAT_ADDR_W = (PAT_TOTAL > 1) ? $clog2(PAT_TOTAL) : 1;

	// fixed field widths
	localparam int ACTION_W = 3;
	localparam int SEL_W    = 3;
	localparam int ENTRY_W  = 4;
	localparam int DUR_W    = 16;
	localparam int PLEN_W   = 8;
	localparam int CNT_W    = 8;
	localparam int TIME_W   = 32;
	localparam int OUT_LEDS = 8;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	// item actions
	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK    = 3'd0,
		ACT_ON      = 3'd1,
		ACT_OFF     = 3'd2,
		ACT_TOGGLE  = 3'd3,
		ACT_ALL_ON  = 3'd4,
		ACT_ALL_OFF = 3'd5,
		ACT_LOAD    = 3'd6,
		ACT_START   = 3'd7
	} action_t;

	// per-led mode
	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2
	} mode_t;

	// per-led sequencing record kept in the record memory
	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic [PAT_AW-1:0] pos;
		logic              started;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  limit;
		logic [TIME_W-1:0] deadline;
	} rec_t;

endpackage

`default_nettype wire

>>> src/lbs_rec_mem.sv
// per-led record memory, registered read, unwritten entries read as zero
`default_nettype none

module lbs_rec_mem (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           rd_en,
	input  wire  [lbs_pkg::LED_W-1:0]     rd_addr,
	output lbs_pkg::rec_t                 rd_data,
	input  wire                           wr_en,
	input  wire  [lbs_pkg::LED_W-1:0]     wr_addr,
	input  lbs_pkg::rec_t                 wr_data
);
	import lbs_pkg::*;

	rec_t               mem [NUM_LEDS];
	logic [NUM_LEDS-1:0] valid_q;
	rec_t               rd_data_q;
	logic               rd_valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// written flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> src/lbs_pat_mem.sv
// pattern duration memory, registered read, unwritten entries read as zero
`default_nettype none

module lbs_pat_mem (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              rd_en,
	input  wire  [lbs_pkg::PAT_ADDR_W-1:0]   rd_addr,
	output logic [lbs_pkg::DUR_W-1:0]        rd_data,
	input  wire                              wr_en,
	input  wire  [lbs_pkg::PAT_ADDR_W-1:0]   wr_addr,
	input  wire  [lbs_pkg::DUR_W-1:0]        wr_data
);
	import lbs_pkg::*;

	logic [DUR_W-1:0]     mem [PAT_TOTAL];
	logic [PAT_TOTAL-1:0] valid_q;
	logic [DUR_W-1:0]     rd_data_q;
	logic                 rd_valid_q;

	// storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// written flags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q  <= mem[rd_addr];
			rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

`default_nettype wire

>>> src/led_blink_sequencer.sv
// led blink sequencer: command handling, tick scan pipeline and result register
//
// Usage: each beat on the s_ channel is one command, its action in s_tuser and
// the operands in s_tdata. Every command yields exactly one beat on m_, carrying
// the pin levels and the blinking mask after the command took effect. The cfg_
// channel writes the active level; it is always ready. The user must write it
// only while no command is in flight; the block itself does not enforce this.
// A start command adds a record read, then a write back, before its result. A
// tick walks the LED records one per cycle through a three-stage
// read / pattern read / write-back pipeline, so the record memory read port
// sets the tick time.
// One command is worked on at a time; s_tready is high while the sequencer is
// idle, and a new command is taken while the previous result still waits in
// the output register. If that register is still full when the next result is
// ready, the sequencer holds the result and stays busy until m_tready.
// Reset clears time, modes, pin levels and the written flags of both
// memories at once; no clearing sweep is needed, and s_tready is high in the
// first cycle after reset.
`default_nettype none

module led_blink_sequencer (
	input  wire                                clk,
	input  wire                                arst_n,
	// command beats
	input  wire                                s_tvalid,
	output logic                               s_tready,
	// led_select, entry_index, duration, pattern_length, blink_limit, set_limit
	input  wire  [lbs_pkg::IN_DATA_W-1:0]      s_tdata,
	// action
	input  wire  [lbs_pkg::ACTION_W-1:0]       s_tuser,
	// result beats
	output logic                               m_tvalid,
	input  wire                                m_tready,
	// pin_levels, blinking_mask
	output logic [lbs_pkg::OUT_DATA_W-1:0]     m_tdata,
	// active level register
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire                                cfg_data
);
	import lbs_pkg::*;

	localparam int VEC_W = (NUM_LEDS > OUT_LEDS) ? NUM_LEDS : OUT_LEDS;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_START = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t              state_q;
	logic                act_lvl_q;
	logic [TIME_W-1:0]   time_q;
	mode_t               mode_q [NUM_LEDS];
	mode_t               mode_d [NUM_LEDS];
	logic [NUM_LEDS-1:0] lvl_q;
	logic [NUM_LEDS-1:0] lvl_d;

	// latched command
	action_t             action_q;
	logic [SEL_W-1:0]    sel_q;
	logic [ENTRY_W-1:0]  entry_q;
	logic [DUR_W-1:0]    dur_q;
	logic [PLEN_W-1:0]   plen_q;
	logic [CNT_W-1:0]    limit_q;
	logic                set_limit_q;

	// scan pipeline
	logic [LED_W-1:0]    scan_q;
	logic                v_s1;
	logic [LED_W-1:0]    led_s1;
	logic                v_s2;
	logic [LED_W-1:0]    led_s2;
	rec_t                rec_s2;

	// memory ports
	logic                rec_rd_en;
	logic [LED_W-1:0]    rec_rd_addr;
	rec_t                rec_rd_data;
	logic                rec_wr_en;
	logic [LED_W-1:0]    rec_wr_addr;
	rec_t                rec_wr_data;
	logic                pat_rd_en;
	logic [PAT_ADDR_W-1:0] pat_rd_addr;
	logic [DUR_W-1:0]    pat_rd_data;
	logic                pat_wr_en;
	logic [PAT_ADDR_W-1:0] pat_wr_addr;

	// output register
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// decoded command
	logic                in_fire;
	logic                led_ok;
	logic                entry_ok;
	logic [LED_W-1:0]    led_idx;
	logic [LEN_W-1:0]    len_clip;

	// step computation on the record in stage 1
	logic                adv_s1;
	logic [LEN_W-1:0]    len_eff;
	logic [LEN_W-1:0]    pos_inc;
	logic [PAT_AW-1:0]   pos_new;
	logic [CNT_W-1:0]    cnt_new;
	logic                lit_s1;
	logic                stop_s1;
	rec_t                rec_new;

	logic                done_fire;
	logic [VEC_W-1:0]    lvl_ext;
	logic [VEC_W-1:0]    blink_ext;
	logic [OUT_LEDS-1:0] mask_now;

	// pin level for a lit or dark led under the current active level
	function automatic logic drive_level(input logic lit, input logic act);
		drive_level = ~(lit ^ act);
	endfunction

	assign in_fire   = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	assign led_ok   = int'(sel_q) < NUM_LEDS;
	assign entry_ok = int'(entry_q) < PATTERN_DEPTH;
	assign led_idx  = LED_W'(sel_q);
	assign len_clip = (int'(plen_q) > PATTERN_DEPTH) ? LEN_W'(PATTERN_DEPTH) : LEN_W'(plen_q);

	// active level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_lvl_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			act_lvl_q <= cfg_data;
		end
	end

	// command latch
	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_q    <= action_t'(s_tuser);
			sel_q       <= s_tdata[2:0];
			entry_q     <= s_tdata[6:3];
			dur_q       <= s_tdata[22:7];
			plen_q      <= s_tdata[30:23];
			limit_q     <= s_tdata[38:31];
			set_limit_q <= s_tdata[39];
		end
	end

	// millisecond counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (in_fire && action_t'(s_tuser) == ACT_TICK) begin
			time_q <= time_q + 1'b1;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scan_q <= '0;
					if (action_q == ACT_TICK) begin
						state_q <= ST_SCAN;
					end else if (action_q == ACT_START && led_ok) begin
						state_q <= ST_START;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_START: begin
					state_q <= ST_DONE;
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (int'(scan_q) == NUM_LEDS - 1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// record memory read: start reads the addressed led, a tick walks all leds
	always_comb begin
		rec_rd_en   = 1'b0;
		rec_rd_addr = scan_q;
		if (state_q == ST_EXEC && action_q == ACT_START && led_ok) begin
			rec_rd_en   = 1'b1;
			rec_rd_addr = led_idx;
		end else if (state_q == ST_SCAN) begin
			rec_rd_en = 1'b1;
		end
	end

	// stage 1: decide the step of one led from its record
	always_comb begin
		len_eff = (rec_rd_data.length == '0) ? LEN_W'(1) : rec_rd_data.length;
		pos_inc = LEN_W'(rec_rd_data.pos) + 1'b1;
		if (!rec_rd_data.started || pos_inc >= len_eff) begin
			pos_new = '0;
		end else begin
			pos_new = PAT_AW'(pos_inc);
		end
		cnt_new = rec_rd_data.count + 1'b1;
		lit_s1  = ~pos_new[0];
		stop_s1 = !lit_s1 && rec_rd_data.limit != '0 && cnt_new >= rec_rd_data.limit;
		adv_s1  = v_s1 && mode_q[led_s1] == MODE_BLINK && time_q > rec_rd_data.deadline;

		rec_new          = rec_rd_data;
		rec_new.pos      = pos_new;
		rec_new.started  = 1'b1;
		rec_new.count    = cnt_new;
		if (stop_s1) begin
			rec_new.count  = '0;
			rec_new.limit  = '0;
			rec_new.length = '0;
		end
	end

	assign pat_rd_en   = adv_s1;
	assign pat_rd_addr = PAT_ADDR_W'(int'(led_s1) * PATTERN_DEPTH + int'(pos_new));

	// scan pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_SCAN);
			v_s2 <= adv_s1;
		end
	end

	// scan pipeline payload
	always_ff @(posedge clk) begin
		led_s1 <= scan_q;
		if (adv_s1) begin
			led_s2 <= led_s1;
			rec_s2 <= rec_new;
		end
	end

	// record write back: start rewrites the record, stage 2 stores a step
	always_comb begin
		rec_wr_en            = 1'b0;
		rec_wr_addr          = led_s2;
		rec_wr_data          = rec_s2;
		rec_wr_data.deadline = time_q + TIME_W'(pat_rd_data);
		if (state_q == ST_START) begin
			rec_wr_en            = 1'b1;
			rec_wr_addr          = led_idx;
			rec_wr_data          = rec_rd_data;
			rec_wr_data.length   = len_clip;
			rec_wr_data.pos      = '0;
			rec_wr_data.started  = 1'b0;
			rec_wr_data.deadline = '0;
			if (set_limit_q) begin
				rec_wr_data.limit = limit_q;
			end
		end else if (v_s2) begin
			rec_wr_en = 1'b1;
		end
	end

	// pattern table load
	assign pat_wr_en   = (state_q == ST_EXEC) && action_q == ACT_LOAD && led_ok && entry_ok;
	assign pat_wr_addr = PAT_ADDR_W'(int'(sel_q) * PATTERN_DEPTH + int'(entry_q));

	// next modes and pin levels
	always_comb begin
		mode_d = mode_q;
		lvl_d  = lvl_q;
		if (state_q == ST_EXEC) begin
			unique case (action_q)
				ACT_ON: begin
					if (led_ok) begin
						mode_d[led_idx] = MODE_ON;
						lvl_d[led_idx]  = drive_level(1'b1, act_lvl_q);
					end
				end
				ACT_OFF: begin
					if (led_ok) begin
						mode_d[led_idx] = MODE_OFF;
						lvl_d[led_idx]  = drive_level(1'b0, act_lvl_q);
					end
				end
				ACT_TOGGLE: begin
					if (led_ok) begin
						if (mode_q[led_idx] == MODE_ON) begin
							mode_d[led_idx] = MODE_OFF;
							lvl_d[led_idx]  = drive_level(1'b0, act_lvl_q);
						end else begin
							mode_d[led_idx] = MODE_ON;
							lvl_d[led_idx]  = drive_level(1'b1, act_lvl_q);
						end
					end
				end
				ACT_ALL_ON: begin
					for (int i = 0; i < NUM_LEDS; i++) begin
						mode_d[i] = MODE_ON;
						lvl_d[i]  = drive_level(1'b1, act_lvl_q);
					end
				end
				ACT_ALL_OFF: begin
					for (int i = 0; i < NUM_LEDS; i++) begin
						mode_d[i] = MODE_OFF;
						lvl_d[i]  = drive_level(1'b0, act_lvl_q);
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_START) begin
			mode_d[led_idx] = MODE_BLINK;
		end
		if (adv_s1) begin
			lvl_d[led_s1] = drive_level(lit_s1, act_lvl_q);
			if (stop_s1) begin
				mode_d[led_s1] = MODE_OFF;
			end
		end
	end

	// mode and pin registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEDS; i++) begin
				mode_q[i] <= MODE_OFF;
			end
			lvl_q <= '0;
		end else begin
			mode_q <= mode_d;
			lvl_q  <= lvl_d;
		end
	end

	// result assembly
	always_comb begin
		blink_ext = '0;
		for (int i = 0; i < NUM_LEDS; i++) begin
			blink_ext[i] = (mode_q[i] == MODE_BLINK);
		end
		lvl_ext  = VEC_W'(lvl_q);
		mask_now = blink_ext[OUT_LEDS-1:0];
	end

	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_data_q <= {mask_now, lvl_ext[OUT_LEDS-1:0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	lbs_rec_mem u_rec_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rec_rd_en),
		.rd_addr (rec_rd_addr),
		.rd_data (rec_rd_data),
		.wr_en   (rec_wr_en),
		.wr_addr (rec_wr_addr),
		.wr_data (rec_wr_data)
	);

	lbs_pat_mem u_pat_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pat_rd_en),
		.rd_addr (pat_rd_addr),
		.rd_data (pat_rd_data),
		.wr_en   (pat_wr_en),
		.wr_addr (pat_wr_addr),
		.wr_data (dur_q)
	);

	// scan pipeline stages only run while a tick is being worked on
	a_pipe_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("scan pipeline active outside a tick");

	// read and write back never meet on the same record
	a_no_rec_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_rd_en && rec_wr_en) |-> (rec_rd_addr != rec_wr_addr))
		else $error("record read and write to the same led");

	// a finished command lands in the output register
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		done_fire |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented after completion");

	// a tick advances time by exactly one
	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_tuser == ACT_TICK) |=> (time_q == $past(time_q) + 1'b1))
		else $error("tick did not advance time");

	// neither memory is written while the sequencer is idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!rec_wr_en && !pat_wr_en))
		else $error("memory write while idle");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for the led blink sequencer: directed and random command streams against a led model
`timescale 1ns / 100ps

module tb_top;
	import lbs_pkg::*;

	localparam int SEND         = 0;
	localparam int RECV         = 1;
	localparam int SETTLE_CYC   = 20;
	localparam int QUIET_LIMIT  = 2000;
	localparam int HOLD_AT_BEAT = 400;
	localparam int HOLD_CYC     = 400;
	localparam int MAX_REPORTS  = 10;

	// one command beat, fields as carried on s_tdata / s_tuser
	typedef struct {
		action_t     action;
		logic [2:0]  led;
		logic [3:0]  entry;
		logic [15:0] dur;
		logic [7:0]  plen;
		logic [7:0]  limit;
		logic        set_limit;
	} led_cmd_t;

	// one result beat
	typedef struct packed {
		logic [7:0] blinking_mask;
		logic [7:0] pin_levels;
	} led_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [ACTION_W-1:0]   s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic                  cfg_data = 1'b0;

	led_blink_sequencer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// led model state
	logic        lit_level;
	logic [31:0] ms_now;
	mode_t       led_mode_m [NUM_LEDS];
	logic [15:0] phase_ticks [NUM_LEDS][PATTERN_DEPTH];
	logic [4:0]  seq_len [NUM_LEDS];
	logic [4:0]  seq_pos [NUM_LEDS];
	logic        seq_begun [NUM_LEDS];
	logic [7:0]  flips [NUM_LEDS];
	logic [7:0]  flip_limit [NUM_LEDS];
	logic [31:0] due_at [NUM_LEDS];
	logic [7:0]  pins;

	// bench state
	led_cmd_t    cmd_q [$];
	led_status_t status_q [$];
	led_cmd_t    cur_cmd;
	logic        cmd_fire = 1'b0;
	logic        res_fire = 1'b0;
	int          calm_left [2];
	int          tx_gap = 0;
	int          rx_stall = 0;
	int          rx_beats = 0;
	int          hold_left = 0;
	bit          hold_done = 0;
	int          quiet_cyc = 0;
	int          mismatch_cnt = 0;

	function automatic void model_reset();
		lit_level = 1'b1;
		ms_now    = '0;
		pins      = '0;
		for (int i = 0; i < NUM_LEDS; i++) begin
			led_mode_m[i] = MODE_OFF;
			seq_len[i]    = '0;
			seq_pos[i]    = '0;
			seq_begun[i]  = 1'b0;
			flips[i]      = '0;
			flip_limit[i] = '0;
			due_at[i]     = '0;
			for (int j = 0; j < PATTERN_DEPTH; j++)
				phase_ticks[i][j] = '0;
		end
	endfunction

	function automatic void light(int i, logic lit);
		pins[i] = lit ? lit_level : ~lit_level;
	endfunction

	function automatic void set_steady(int i, logic on);
		led_mode_m[i] = on ? MODE_ON : MODE_OFF;
		light(i, on);
	endfunction

	// one tick step of a blinking led once its deadline has strictly passed
	function automatic void advance_led(int i);
		logic [4:0] n;
		logic [4:0] p;
		if (ms_now <= due_at[i])
			return;
		n = (seq_len[i] == 0) ? 5'd1 : seq_len[i];
		if (!seq_begun[i]) begin
			p = '0;
		end else begin
			p = seq_pos[i] + 5'd1;
			if (p >= n)
				p = '0;
		end
		seq_pos[i]   = p;
		seq_begun[i] = 1'b1;
		flips[i]     = flips[i] + 8'd1;
		if (!p[0]) begin
			light(i, 1'b1);
		end else begin
			light(i, 1'b0);
			// limit reached on a dark phase: back to off
			if (flip_limit[i] != 0 && flips[i] >= flip_limit[i]) begin
				led_mode_m[i] = MODE_OFF;
				flips[i]      = '0;
				flip_limit[i] = '0;
				seq_len[i]    = '0;
			end
		end
		due_at[i] = ms_now + 32'(phase_ticks[i][p[3:0]]);
	endfunction

	// apply one command to the model and return the pins and mask after it
	function automatic led_status_t predict_status(led_cmd_t c);
		led_status_t s;
		int          l;
		l = int'(c.led);
		case (c.action)
			ACT_TICK: begin
				ms_now = ms_now + 32'd1;
				for (int i = 0; i < NUM_LEDS; i++)
					if (led_mode_m[i] == MODE_BLINK)
						advance_led(i);
			end
			ACT_ON:     set_steady(l, 1'b1);
			ACT_OFF:    set_steady(l, 1'b0);
			ACT_TOGGLE: set_steady(l, led_mode_m[l] != MODE_ON);
			ACT_ALL_ON: begin
				for (int i = 0; i < NUM_LEDS; i++)
					set_steady(i, 1'b1);
			end
			ACT_ALL_OFF: begin
				for (int i = 0; i < NUM_LEDS; i++)
					set_steady(i, 1'b0);
			end
			ACT_LOAD:   phase_ticks[l][c.entry] = c.dur;
			ACT_START: begin
				if (c.set_limit)
					flip_limit[l] = c.limit;
				led_mode_m[l] = MODE_BLINK;
				seq_len[l]    = (c.plen > PATTERN_DEPTH) ? 5'(PATTERN_DEPTH) : c.plen[4:0];
				seq_begun[l]  = 1'b0;
				seq_pos[l]    = '0;
				due_at[l]     = '0;
			end
		endcase
		s.pin_levels = pins;
		for (int i = 0; i < 8; i++)
			s.blinking_mask[i] = (led_mode_m[i] == MODE_BLINK);
		return s;
	endfunction

	function automatic led_cmd_t make_cmd(action_t a, int led, int entry, int dur,
	                                      int plen, int lim, bit setl);
		led_cmd_t c;
		c.action    = a;
		c.led       = 3'(led);
		c.entry     = 4'(entry);
		c.dur       = 16'(dur);
		c.plen      = 8'(plen);
		c.limit     = 8'(lim);
		c.set_limit = setl;
		return c;
	endfunction

	// wait per beat, with occasional runs of back-to-back beats
	function automatic int draw_wait(int side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			calm_left[side] = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 14);
	endfunction

	// mostly load-start-tick programs with random content, plus tick runs and noise
	task automatic queue_random_phase(input int n);
		int added;
		int led;
		int k;
		int lim;
		added = 0;
		while (added < n) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					led = $urandom_range(0, NUM_LEDS - 1);
					k   = $urandom_range(1, 6);
					for (int j = 0; j < k; j++) begin
						cmd_q.push_back(make_cmd(ACT_LOAD, led, j,
							($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
							                            : $urandom_range(0, 4), 0, 0, 0));
						added++;
					end
					case ($urandom_range(0, 3))
						0:       lim = 0;
						1:       lim = $urandom_range(0, 255);
						default: lim = $urandom_range(1, 12);
					endcase
					cmd_q.push_back(make_cmd(ACT_START, led, 0, 0,
						($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : k,
						lim, $urandom_range(0, 4) != 0));
					added++;
					k = $urandom_range(4, 25);
					for (int j = 0; j < k; j++)
						cmd_q.push_back(make_cmd(ACT_TICK, $urandom_range(0, 7), 0, 0, 0, 0, 0));
					added += k;
				end
				4, 5, 6: begin
					k = $urandom_range(1, 10);
					for (int j = 0; j < k; j++)
						cmd_q.push_back(make_cmd(ACT_TICK, $urandom_range(0, 7),
							$urandom_range(0, 15), $urandom_range(0, 65535), 0, 0, 0));
					added += k;
				end
				default: begin
					cmd_q.push_back(make_cmd(action_t'($urandom_range(0, 7)),
						$urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 65535),
						$urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 1)));
					added++;
				end
			endcase
		end
	endtask

	// wait until every beat is sent and answered, then let the block settle
	task automatic drain();
		while (cmd_q.size() != 0 || s_tvalid || status_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_level(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// command driver
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || cmd_fire)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				cur_cmd = cmd_q.pop_front();
				s_tdata  <= {cur_cmd.set_limit, cur_cmd.limit, cur_cmd.plen, cur_cmd.dur,
				             cur_cmd.entry, cur_cmd.led};
				s_tuser  <= cur_cmd.action;
				s_tvalid <= 1'b1;
				tx_gap = draw_wait(SEND);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// result receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_fire) begin
				rx_beats++;
				rx_stall = draw_wait(RECV);
			end
			if (rx_beats == HOLD_AT_BEAT && !hold_done) begin
				hold_done = 1;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor: predict on command beats, check result beats, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			cmd_fire <= s_tvalid && s_tready;
			res_fire <= m_tvalid && m_tready;
			if (m_tvalid && m_tready) begin
				if (status_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("unexpected result beat: %h", m_tdata);
				end else begin
					led_status_t want;
					want = status_q.pop_front();
					if (m_tdata[7:0] !== want.pin_levels) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTS)
							$display("pin_levels mismatch: expected %h actual %h",
							         want.pin_levels, m_tdata[7:0]);
					end
					if (m_tdata[15:8] !== want.blinking_mask) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTS)
							$display("blinking_mask mismatch: expected %h actual %h",
							         want.blinking_mask, m_tdata[15:8]);
					end
				end
			end
			if (s_tvalid && s_tready)
				status_q.push_back(predict_status(cur_cmd));
			if (cfg_valid && cfg_ready)
				lit_level = cfg_data;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= QUIET_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		model_reset();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every action, zero length, clipping, limit stop, toggle of blink
		cmd_q.push_back(make_cmd(ACT_LOAD, 0, 0, 2, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_LOAD, 0, 1, 1, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_LOAD, 0, 15, 16'hffff, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_LOAD, 7, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_ON, 7, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_OFF, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_TOGGLE, 3, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_TOGGLE, 3, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_ALL_ON, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_ALL_OFF, 7, 15, 16'hffff, 255, 255, 1));
		cmd_q.push_back(make_cmd(ACT_START, 0, 0, 0, 0, 0, 1));
		cmd_q.push_back(make_cmd(ACT_START, 7, 0, 0, 255, 255, 1));
		cmd_q.push_back(make_cmd(ACT_START, 5, 0, 0, 2, 3, 1));
		for (int j = 0; j < 6; j++)
			cmd_q.push_back(make_cmd(ACT_TICK, 0, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_TOGGLE, 7, 0, 0, 0, 0, 0));
		cmd_q.push_back(make_cmd(ACT_START, 5, 0, 0, 16, 200, 0));
		for (int j = 0; j < 3; j++)
			cmd_q.push_back(make_cmd(ACT_TICK, 7, 15, 16'hffff, 255, 255, 1));
		cmd_q.push_back(make_cmd(ACT_ALL_ON, 7, 15, 16'hffff, 255, 255, 1));
		drain();

		// random phases under both active levels
		write_level(1'b0);
		queue_random_phase(330);
		drain();
		write_level(1'b1);
		queue_random_phase(330);
		drain();
		write_level(1'b0);
		queue_random_phase(340);
		drain();

		if (mismatch_cnt == 0 && status_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> sim.f
src/lbs_pkg.sv
src/lbs_rec_mem.sv
src/lbs_pat_mem.sv
src/led_blink_sequencer.sv
tb/sv/tb_top.sv
